// File: src/vrd_pkg.sv
package vrd_pkg;

   typedef enum logic [1:0] {
      PH_VARINT  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      K_VALUE   = 2'd0,
      K_PAYLOAD = 2'd1,
      K_EMPTY   = 2'd2,
      K_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_TRUNC = 2'd1,
      ERR_LONG  = 2'd2
   } err_type;

   localparam logic [1:0] MODE_VARINT32 = 2'd0;
   localparam logic [1:0] MODE_VARINT64 = 2'd1;
   localparam logic [1:0] MODE_RECORD   = 2'd2;

   localparam logic [3:0] MAX_BYTES_32 = 4'd5;
   localparam logic [3:0] MAX_BYTES_64 = 4'd10;

   localparam logic [5:0] MAX_SHIFT = 6'd63;

   localparam logic [2:0] CSR_IDX_MODE = 3'd0;

endpackage

// File: src/varint_record_deframer.sv
// Decodes a byte stream of little-endian base-128 varints, one input word per clock
// cycle with no bubbles: each byte is handled by a single pass of shallow logic between the
// parser state registers and a one-entry result register, so throughput is one byte per cycle
// and a result appears the cycle after its byte is taken. req_ready stays high while the result
// register is empty or being drained in the same cycle, so only a stalled rsp_ready holds off
// input. The mode register (byte address 0) selects varint32 values, varint64 values or
// length-prefixed records; it is sampled on every byte and should be written while the block is
// idle. Errors are reported once per buffer, and every end-of-buffer byte resets the parser.
module varint_record_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [63:0] rsp_decoded_value,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_of_record,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [1:0]          mode_ff;
   logic [63:0]         acc_ff, acc_in;
   logic [3:0]          idx_ff, idx_in;
   vrd_pkg::phase_type  phase_ff, phase_in;
   logic [31:0]         left_ff, left_in;

   logic                rsp_valid_ff, rsp_valid_in;
   vrd_pkg::kind_type   kind_ff, kind_in;
   logic [63:0]         value_ff, value_in;
   logic [7:0]          pbyte_ff, pbyte_in;
   logic                last_ff, last_in;
   vrd_pkg::err_type    err_ff, err_in;
   logic                produce;

   logic                accept;
   logic                wide;
   logic [3:0]          max_bytes;
   logic [6:0]          shift_wide;
   logic [5:0]          shift_amt;
   logic [63:0]         acc_or;
   logic [3:0]          idx_inc;
   logic [31:0]         left_dec;
   logic                cont;
   logic                csr_write;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == vrd_pkg::CSR_IDX_MODE) ? {30'd0, mode_ff} : 32'd0;

   assign wide       = (mode_ff == vrd_pkg::MODE_VARINT64);
   assign max_bytes  = wide ? vrd_pkg::MAX_BYTES_64 : vrd_pkg::MAX_BYTES_32;
   assign shift_wide = {3'd0, idx_ff} * 7'd7;
   assign shift_amt  = (shift_wide > {1'b0, vrd_pkg::MAX_SHIFT}) ? vrd_pkg::MAX_SHIFT
                                                                 : shift_wide[5:0];
   assign cont       = req_in_byte[7];
   assign idx_inc    = idx_ff + 4'd1;
   assign left_dec   = left_ff - 32'd1;

   always_comb begin
      acc_or = acc_ff | ({57'd0, req_in_byte[6:0]} << shift_amt);
      if (!wide) begin
         acc_or[63:32] = 32'd0;
      end
   end

   // Next parser phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         vrd_pkg::PH_PAYLOAD: begin
            if (left_dec == 32'd0) begin
               phase_in = vrd_pkg::PH_VARINT;
            end
         end
         vrd_pkg::PH_VARINT: begin
            if (cont) begin
               if (idx_inc >= max_bytes) begin
                  phase_in = vrd_pkg::PH_DISCARD;
               end
            end else if (mode_ff == vrd_pkg::MODE_RECORD && acc_or[31:0] != 32'd0) begin
               phase_in = vrd_pkg::PH_PAYLOAD;
            end
         end
         default: phase_in = phase_ff;
      endcase
      if (req_end_of_buffer) begin
         phase_in = vrd_pkg::PH_VARINT;
      end
   end

   // Datapath state and result fields.
   always_comb begin
      acc_in   = acc_ff;
      idx_in   = idx_ff;
      left_in  = left_ff;
      produce  = 1'b0;
      kind_in  = vrd_pkg::K_VALUE;
      value_in = 64'd0;
      pbyte_in = 8'd0;
      last_in  = 1'b0;
      err_in   = vrd_pkg::ERR_NONE;
      case (phase_ff)
         vrd_pkg::PH_PAYLOAD: begin
            produce = 1'b1;
            left_in = left_dec;
            if (left_dec == 32'd0) begin
               kind_in  = vrd_pkg::K_PAYLOAD;
               pbyte_in = req_in_byte;
               last_in  = 1'b1;
               acc_in   = 64'd0;
               idx_in   = 4'd0;
            end else if (req_end_of_buffer) begin
               kind_in = vrd_pkg::K_ERROR;
               err_in  = vrd_pkg::ERR_TRUNC;
            end else begin
               kind_in  = vrd_pkg::K_PAYLOAD;
               pbyte_in = req_in_byte;
            end
         end
         vrd_pkg::PH_VARINT: begin
            acc_in = acc_or;
            if (cont) begin
               idx_in = idx_inc;
               if (idx_inc >= max_bytes) begin
                  produce = 1'b1;
                  kind_in = vrd_pkg::K_ERROR;
                  err_in  = vrd_pkg::ERR_LONG;
               end else if (req_end_of_buffer) begin
                  produce = 1'b1;
                  kind_in = vrd_pkg::K_ERROR;
                  err_in  = vrd_pkg::ERR_TRUNC;
               end
            end else if (mode_ff == vrd_pkg::MODE_RECORD) begin
               acc_in = 64'd0;
               idx_in = 4'd0;
               if (acc_or[31:0] == 32'd0) begin
                  produce = 1'b1;
                  kind_in = vrd_pkg::K_EMPTY;
                  last_in = 1'b1;
               end else if (req_end_of_buffer) begin
                  produce = 1'b1;
                  kind_in = vrd_pkg::K_ERROR;
                  err_in  = vrd_pkg::ERR_TRUNC;
               end else begin
                  left_in = acc_or[31:0];
               end
            end else begin
               produce  = 1'b1;
               kind_in  = vrd_pkg::K_VALUE;
               value_in = acc_or;
               acc_in   = 64'd0;
               idx_in   = 4'd0;
            end
         end
         default: produce = 1'b0;
      endcase
      if (req_end_of_buffer) begin
         acc_in  = 64'd0;
         idx_in  = 4'd0;
         left_in = 32'd0;
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = produce;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= vrd_pkg::MODE_VARINT32;
         acc_ff       <= 64'd0;
         idx_ff       <= 4'd0;
         phase_ff     <= vrd_pkg::PH_VARINT;
         left_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && csr_paddr == vrd_pkg::CSR_IDX_MODE) begin
            mode_ff <= csr_pwdata[1:0];
         end
         if (accept) begin
            acc_ff   <= acc_in;
            idx_ff   <= idx_in;
            phase_ff <= phase_in;
            left_ff  <= left_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produce) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
         pbyte_ff <= pbyte_in;
         last_ff  <= last_in;
         err_ff   <= err_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_decoded_value  = value_ff;
   assign rsp_payload_byte   = pbyte_ff;
   assign rsp_last_of_record = last_ff;
   assign rsp_error_code     = err_ff;

   a_eob_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_buffer) |=>
         (phase_ff == vrd_pkg::PH_VARINT && idx_ff == 4'd0 && left_ff == 32'd0))
      else $error("parser not cleared after end of buffer");

   a_payload_owed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == vrd_pkg::PH_PAYLOAD) |-> (left_ff != 32'd0))
      else $error("payload phase with nothing owed");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == vrd_pkg::PH_VARINT) |-> (idx_ff < vrd_pkg::MAX_BYTES_64))
      else $error("varint byte index out of range");

   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((kind_ff == vrd_pkg::K_ERROR) == (err_ff != vrd_pkg::ERR_NONE)))
      else $error("error code does not match result kind");

   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == vrd_pkg::K_ERROR) |->
         (!last_ff && value_ff == 64'd0 && pbyte_ff == 8'd0))
      else $error("error word carries data");

endmodule
